>>> src/rc_pkg.sv
// Shared types, constants and register codes for the repetition counter.
`default_nettype none

package rc_pkg;

   // Field widths
   localparam int DIST_WIDTH     = 16;
   localparam int TIME_WIDTH     = 32;
   localparam int COUNT_WIDTH    = 16;
   localparam int TRAVEL_WIDTH   = 14;
   localparam int IDLE_WIDTH     = 16;
   localparam int ASC_THR_WIDTH  = 13;
   localparam int QUARTER_WIDTH  = TRAVEL_WIDTH - 2;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MIN_TRAVEL = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_IDLE   = 2'd1;

   // Reset values of the configuration registers
   localparam logic [TRAVEL_WIDTH-1:0]  MIN_TRAVEL_RESET = 14'd1000;
   localparam logic [IDLE_WIDTH-1:0]    MAX_IDLE_RESET   = 16'd5000;
   localparam logic [ASC_THR_WIDTH-1:0] ASC_THR_RESET    = 13'd300;

   // A distance change above this counts as movement (0.20 cm)
   localparam logic [DIST_WIDTH-1:0]  MOVE_THRESHOLD = 16'd20;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = 16'hFFFF;

   // floor(3*x/10) as x * (3 * 52429) >> 19, exact for every 14-bit x
   localparam logic [17:0] ASC_RECIP = 18'd157287;
   localparam int          ASC_SHIFT = 19;

   typedef enum logic [1:0] {
      PHASE_WAIT = 2'd0,
      PHASE_ASC  = 2'd1,
      PHASE_DESC = 2'd2
   } phase_type;

   // Configuration as seen by the step logic
   typedef struct packed {
      logic [TRAVEL_WIDTH-1:0]  min_travel;
      logic [IDLE_WIDTH-1:0]    max_idle;
      logic [ASC_THR_WIDTH-1:0] asc_thr;
      logic [QUARTER_WIDTH-1:0] quarter;
   } cfg_type;

   // Tracking state carried from one sample to the next
   typedef struct packed {
      logic                   primed;
      phase_type              phase;
      logic [COUNT_WIDTH-1:0] count;
      logic [DIST_WIDTH-1:0]  bottom_ref;
      logic [DIST_WIDTH-1:0]  peak_dist;
      logic [DIST_WIDTH-1:0]  descent_goal;
      logic [DIST_WIDTH-1:0]  prev_dist;
      logic [TIME_WIDTH-1:0]  last_move_ms;
   } state_type;

   // One input word
   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      logic [TIME_WIDTH-1:0] now_ms;
      logic                  restart;
   } req_type;

   // One result word
   typedef struct packed {
      logic                   rep_done;
      logic [COUNT_WIDTH-1:0] reps_total;
      phase_type              phase_now;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/rc_csr.sv
// Configuration registers and the thresholds derived from them.
`default_nettype none

module rc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [rc_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [rc_pkg::CSR_DATA_WIDTH-1:0] csr_write_data,
   output rc_pkg::cfg_type                        cfg
);

   logic [rc_pkg::TRAVEL_WIDTH-1:0]  min_travel_ff, min_travel_in;
   logic [rc_pkg::IDLE_WIDTH-1:0]    max_idle_ff, max_idle_in;
   logic [rc_pkg::ASC_THR_WIDTH-1:0] asc_thr_ff, asc_thr_in;
   logic [rc_pkg::TRAVEL_WIDTH-1:0]  travel_wr;
   logic [rc_pkg::IDLE_WIDTH-1:0]    idle_wr;
   logic [31:0]                      asc_prod;

   assign travel_wr = csr_write_data[rc_pkg::TRAVEL_WIDTH-1:0];
   assign idle_wr   = csr_write_data[rc_pkg::IDLE_WIDTH-1:0];

   // The ascending threshold is worked out once, when min_travel is written.
   assign asc_prod = 32'({18'd0, travel_wr} * {14'd0, rc_pkg::ASC_RECIP});

   // A write of zero leaves the register as it was.
   always_comb begin
      min_travel_in = min_travel_ff;
      max_idle_in   = max_idle_ff;
      asc_thr_in    = asc_thr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rc_pkg::CSR_MIN_TRAVEL: begin
               if (travel_wr != '0) begin
                  min_travel_in = travel_wr;
                  asc_thr_in    = asc_prod[rc_pkg::ASC_SHIFT +: rc_pkg::ASC_THR_WIDTH];
               end
            end
            rc_pkg::CSR_MAX_IDLE: begin
               if (idle_wr != '0) begin
                  max_idle_in = idle_wr;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_travel_ff <= rc_pkg::MIN_TRAVEL_RESET;
         max_idle_ff   <= rc_pkg::MAX_IDLE_RESET;
         asc_thr_ff    <= rc_pkg::ASC_THR_RESET;
      end else begin
         min_travel_ff <= min_travel_in;
         max_idle_ff   <= max_idle_in;
         asc_thr_ff    <= asc_thr_in;
      end
   end

   assign cfg.min_travel = min_travel_ff;
   assign cfg.max_idle   = max_idle_ff;
   assign cfg.asc_thr    = asc_thr_ff;
   assign cfg.quarter    = min_travel_ff[rc_pkg::TRAVEL_WIDTH-1:2];

endmodule

`default_nettype wire

>>> src/rc_step.sv
// Combinational update of the tracking state for one distance sample.
`default_nettype none

module rc_step (
   input  wire rc_pkg::cfg_type   cfg,
   input  wire rc_pkg::state_type state_cur,
   input  wire rc_pkg::req_type   req,
   output rc_pkg::state_type      state_next,
   output rc_pkg::rsp_type        rsp
);

   rc_pkg::state_type             base;
   logic [rc_pkg::DIST_WIDTH-1:0] d;
   logic [rc_pkg::DIST_WIDTH-1:0] move_mag;
   logic [rc_pkg::DIST_WIDTH-1:0] bottom_new;
   logic [rc_pkg::DIST_WIDTH-1:0] peak_new;
   logic [rc_pkg::TIME_WIDTH-1:0] idle_time;
   logic                          done;

   assign d = req.distance;

   // Restart clears the tracking state before the sample is applied.
   always_comb begin
      base = state_cur;
      if (req.restart) begin
         base = '0;
         base.phase = rc_pkg::PHASE_WAIT;
      end
   end

   assign move_mag   = (d > base.prev_dist) ? (d - base.prev_dist) : (base.prev_dist - d);
   assign bottom_new = (d > base.bottom_ref) ? d : base.bottom_ref;
   assign peak_new   = (d < base.peak_dist) ? d : base.peak_dist;

   // Phase machine, then the idle check on the updated movement time.
   always_comb begin
      state_next = base;
      done       = 1'b0;
      idle_time  = '0;
      if (!base.primed) begin
         state_next.primed       = 1'b1;
         state_next.bottom_ref   = d;
         state_next.peak_dist    = d;
         state_next.descent_goal = d;
         state_next.prev_dist    = d;
         state_next.last_move_ms = req.now_ms;
      end else begin
         if (move_mag > rc_pkg::MOVE_THRESHOLD) begin
            state_next.last_move_ms = req.now_ms;
         end
         state_next.prev_dist  = d;
         state_next.bottom_ref = bottom_new;

         case (base.phase)
            rc_pkg::PHASE_ASC: begin
               state_next.peak_dist = peak_new;
               if ((d - peak_new) >= {3'd0, cfg.asc_thr}) begin
                  state_next.phase = rc_pkg::PHASE_DESC;
               end
            end
            rc_pkg::PHASE_DESC: begin
               if (({1'b0, d} + {5'd0, cfg.quarter}) >= {1'b0, base.descent_goal}) begin
                  done = 1'b1;
                  if (base.count != rc_pkg::COUNT_MAX) begin
                     state_next.count = base.count + 1'b1;
                  end
                  state_next.phase        = rc_pkg::PHASE_WAIT;
                  state_next.bottom_ref   = d;
                  state_next.peak_dist    = d;
                  state_next.descent_goal = d;
                  state_next.last_move_ms = req.now_ms;
               end
            end
            default: begin
               state_next.phase = rc_pkg::PHASE_WAIT;
               if ((bottom_new - d) >= {2'd0, cfg.min_travel}) begin
                  state_next.phase        = rc_pkg::PHASE_ASC;
                  state_next.peak_dist    = d;
                  state_next.descent_goal = bottom_new;
               end
            end
         endcase

         idle_time = req.now_ms - state_next.last_move_ms;
         if (idle_time > {16'd0, cfg.max_idle}) begin
            state_next.phase        = rc_pkg::PHASE_WAIT;
            state_next.bottom_ref   = d;
            state_next.peak_dist    = d;
            state_next.descent_goal = d;
         end
      end
   end

   assign rsp.rep_done   = done;
   assign rsp.reps_total = state_next.count;
   assign rsp.phase_now  = state_next.phase;

endmodule

`default_nettype wire

>>> src/repetition_counter.sv
// Top level of the repetition counter: input register, tracking state, result register.
//
// Usage: distance samples arrive on the req_ channel, one word per sample, with a
// millisecond timestamp and a restart flag. Every sample gives exactly one word on
// the rsp_ channel: whether it completed a repetition, the saturating count and the
// phase after the sample. A word moves when valid is high and stall is low.
// A sample accepted into the input register is processed by the step logic into the
// result register and shown on rsp_ from then on. Throughput: one sample per cycle
// while the receiver does not stall; the tracking state goes round the combinational
// step logic, so each sample sees the state left by the one before it.
// When the receiver stalls, the result register holds its word and the input
// register fills; req_stall then rises until the result is taken.
// Configuration (min_travel, max_idle) must be written on the csr_ port only while no
// sample is in flight, which the block does not enforce; a write of zero is ignored.
// Reset (synchronous, active high) empties both registers, clears the count and
// references, and loads min_travel 1000 and max_idle 5000.
`default_nettype none

module repetition_counter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [rc_pkg::DIST_WIDTH-1:0]     req_distance,
   input  wire logic [rc_pkg::TIME_WIDTH-1:0]     req_now_ms,
   input  wire logic                              req_restart,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_rep_done,
   output logic [rc_pkg::COUNT_WIDTH-1:0]         rsp_reps_total,
   output logic [1:0]                             rsp_phase_now,
   input  wire logic                              csr_write_enable,
   input  wire logic [rc_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [rc_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);

   rc_pkg::cfg_type   cfg;
   rc_pkg::req_type   in_ff, in_in;
   logic              in_valid_ff, in_valid_in;
   rc_pkg::state_type state_ff, state_in, state_step;
   rc_pkg::rsp_type   out_ff, out_in, out_step;
   logic              out_valid_ff, out_valid_in;
   logic              advance;
   logic              step_fire;
   logic              req_take;

   rc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rc_step u_step (
      .cfg        (cfg),
      .state_cur  (state_ff),
      .req        (in_ff),
      .state_next (state_step),
      .rsp        (out_step)
   );

   // The result register can take a new word when empty or being read.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Input register
   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_in.distance = req_distance;
         in_in.now_ms   = req_now_ms;
         in_in.restart  = req_restart;
         in_valid_in    = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Tracking state and result register
   always_comb begin
      state_in     = state_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (step_fire) begin
         state_in     = state_step;
         out_in       = out_step;
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // An all-zero state is unprimed and waiting at the bottom.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_rep_done   = out_ff.rep_done;
   assign rsp_reps_total = out_ff.reps_total;
   assign rsp_phase_now  = out_ff.phase_now;

   // The count only falls when a sample carries restart.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      step_fire && !in_ff.restart |=> state_ff.count >= $past(state_ff.count))
      else $error("repetition count fell without a restart");

   // A completed repetition leaves the machine waiting at the bottom.
   a_done_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rep_done |-> rsp_phase_now == rc_pkg::PHASE_WAIT)
      else $error("repetition completed outside the waiting phase");

   // A completed repetition always has a non-zero count.
   a_done_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rep_done |-> rsp_reps_total != '0)
      else $error("repetition completed with a zero count");

   // The input side only stalls when its register holds a word.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

>>> bench/tb_repetition_counter.sv
// Self-checking testbench for the repetition counter, with directed and random runs.
`timescale 1ns / 1ps

module tb_repetition_counter;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int ROUND_WORDS    = 75;

   // Spare register indexes that the block must ignore
   localparam logic [rc_pkg::CSR_IDX_WIDTH-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [rc_pkg::CSR_IDX_WIDTH-1:0] CSR_SPARE_B = 2'd3;

   logic                              clock;
   logic                              reset            = 1'b1;
   logic                              req_valid        = 1'b0;
   logic                              req_stall;
   logic [rc_pkg::DIST_WIDTH-1:0]     req_distance     = '0;
   logic [rc_pkg::TIME_WIDTH-1:0]     req_now_ms       = '0;
   logic                              req_restart      = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall        = 1'b0;
   logic                              rsp_rep_done;
   logic [rc_pkg::COUNT_WIDTH-1:0]    rsp_reps_total;
   logic [1:0]                        rsp_phase_now;
   logic                              csr_write_enable = 1'b0;
   logic [rc_pkg::CSR_IDX_WIDTH-1:0]  csr_index        = '0;
   logic [rc_pkg::CSR_DATA_WIDTH-1:0] csr_write_data   = '0;

   // Mirror of the configuration registers
   logic [rc_pkg::TRAVEL_WIDTH-1:0] travel_min;
   logic [rc_pkg::IDLE_WIDTH-1:0]   idle_limit;

   // Mirror of the tracking state
   logic                           armed;
   rc_pkg::phase_type              cur_phase;
   logic [rc_pkg::COUNT_WIDTH-1:0] reps;
   logic [rc_pkg::DIST_WIDTH-1:0]  far_ref;
   logic [rc_pkg::DIST_WIDTH-1:0]  low_mark;
   logic [rc_pkg::DIST_WIDTH-1:0]  return_goal;
   logic [rc_pkg::DIST_WIDTH-1:0]  last_dist;
   logic [rc_pkg::TIME_WIDTH-1:0]  moved_at;

   rc_pkg::rsp_type pending_results[$];
   int              mismatches   = 0;
   int              words_sent   = 0;
   int              quiet_cycles = 0;

   // Traffic shaping, changed by the tests
   int stall_pct  = 0;
   int stall_left = 0;
   int gap_max    = 0;
   int burst_max  = 1;
   int burst_left = 0;
   logic [rc_pkg::TIME_WIDTH-1:0] clock_ms;

   repetition_counter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_distance     (req_distance),
      .req_now_ms       (req_now_ms),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rep_done     (rsp_rep_done),
      .rsp_reps_total   (rsp_reps_total),
      .rsp_phase_now    (rsp_phase_now),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Clears everything that a restart or reset clears.
   function automatic void forget_tracking();
      armed       = 1'b0;
      cur_phase   = rc_pkg::PHASE_WAIT;
      reps        = '0;
      far_ref     = '0;
      low_mark    = '0;
      return_goal = '0;
      last_dist   = '0;
      moved_at    = '0;
   endfunction

   function automatic void rebase_marks(input logic [rc_pkg::DIST_WIDTH-1:0] d);
      far_ref     = d;
      low_mark    = d;
      return_goal = d;
   endfunction

   // Works out the result word for one sample and advances the mirrored state.
   function automatic rc_pkg::rsp_type predict_sample(input rc_pkg::req_type s);
      rc_pkg::rsp_type               r;
      int                            swing;
      int                            floor_lim;
      int                            rise_need;
      logic [rc_pkg::TIME_WIDTH-1:0] quiet_ms;
      r.rep_done = 1'b0;
      if (s.restart)
         forget_tracking();
      if (!armed) begin
         // The first sample only sets the references.
         armed = 1'b1;
         rebase_marks(s.distance);
         last_dist = s.distance;
         moved_at  = s.now_ms;
      end else begin
         swing = int'(s.distance) - int'(last_dist);
         if (swing > int'(rc_pkg::MOVE_THRESHOLD) || swing < -int'(rc_pkg::MOVE_THRESHOLD))
            moved_at = s.now_ms;
         last_dist = s.distance;
         if (s.distance > far_ref)
            far_ref = s.distance;
         case (cur_phase)
            rc_pkg::PHASE_ASC: begin
               if (s.distance < low_mark)
                  low_mark = s.distance;
               rise_need = (3 * int'(travel_min)) / 10;
               if (int'(s.distance) - int'(low_mark) >= rise_need)
                  cur_phase = rc_pkg::PHASE_DESC;
            end
            rc_pkg::PHASE_DESC: begin
               // The limit may go below zero, in which case any sample counts.
               floor_lim = int'(return_goal) - int'(travel_min) / 4;
               if (int'(s.distance) >= floor_lim) begin
                  if (reps != rc_pkg::COUNT_MAX)
                     reps++;
                  cur_phase = rc_pkg::PHASE_WAIT;
                  rebase_marks(s.distance);
                  moved_at   = s.now_ms;
                  r.rep_done = 1'b1;
               end
            end
            default: begin
               cur_phase = rc_pkg::PHASE_WAIT;
               if (int'(far_ref) - int'(s.distance) >= int'(travel_min)) begin
                  cur_phase   = rc_pkg::PHASE_ASC;
                  low_mark    = s.distance;
                  return_goal = far_ref;
               end
            end
         endcase
         quiet_ms = s.now_ms - moved_at;
         if (quiet_ms > idle_limit) begin
            cur_phase = rc_pkg::PHASE_WAIT;
            rebase_marks(s.distance);
         end
      end
      r.reps_total = reps;
      r.phase_now  = cur_phase;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input int unsigned want_v,
                                input int unsigned got_v);
      mismatches++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, what, want_v, got_v);
   endtask

   // Sends one word, in bursts with random gaps, and records its expected result.
   task automatic send_sample(input logic [rc_pkg::DIST_WIDTH-1:0] sample_d,
                              input logic [rc_pkg::TIME_WIDTH-1:0] stamp, input logic fresh);
      rc_pkg::req_type word;
      int              gap;
      word.distance = sample_d;
      word.now_ms   = stamp;
      word.restart  = fresh;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_distance <= sample_d;
      req_now_ms   <= stamp;
      req_restart  <= fresh;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_results.push_back(predict_sample(word));
      words_sent++;
   endtask

   // Stops sending and waits until every expected word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_results.size() != 0);
   endtask

   task automatic write_reg(input logic [rc_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input logic [rc_pkg::CSR_DATA_WIDTH-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      // Writes of zero and writes to spare indexes leave the registers alone.
      case (idx)
         rc_pkg::CSR_MIN_TRAVEL:
            if (value[rc_pkg::TRAVEL_WIDTH-1:0] != '0)
               travel_min = value[rc_pkg::TRAVEL_WIDTH-1:0];
         rc_pkg::CSR_MAX_IDLE:
            if (value != '0) idle_limit = value;
         default: ;
      endcase
   endtask

   // Moves from one distance to another in a few samples with a little jitter.
   task automatic glide(input int from_d, input int to_d);
      int steps;
      int d;
      int jit;
      steps = $urandom_range(1, 4);
      for (int k = 1; k <= steps; k++) begin
         jit = $urandom_range(0, 20);
         d   = from_d + (to_d - from_d) * k / steps + jit - 10;
         if (d < 0)
            d = 0;
         else if (d > 65535)
            d = 65535;
         // Now and then the timestamp jumps by half to twice the idle limit, which may trip it.
         if ($urandom_range(0, 39) == 0)
            clock_ms += $urandom_range(int'(idle_limit) / 2, int'(idle_limit) * 2);
         else
            clock_ms += $urandom_range(1, 60);
         send_sample(d[rc_pkg::DIST_WIDTH-1:0], clock_ms, 1'b0);
      end
   endtask

   // One repetition shaped movement: down from the top, up again, back near the top.
   task automatic rep_motion();
      int top;
      int dip;
      int low;
      int high;
      int back;
      int a;
      int b;
      top = $urandom_range(int'(travel_min), 65535);
      a   = $urandom_range(0, int'(travel_min) / 2);
      b   = $urandom_range(0, int'(travel_min) / 8);
      dip = int'(travel_min) + a - b;
      low = (top > dip) ? top - dip : 0;
      a    = $urandom_range(0, int'(travel_min) / 5);
      b    = $urandom_range(0, int'(travel_min) / 10);
      high = low + (3 * int'(travel_min)) / 10 + a - b;
      if (high > 65535)
         high = 65535;
      a    = $urandom_range(0, int'(travel_min) / 3);
      back = top - a;
      clock_ms += $urandom_range(1, 60);
      send_sample(top[rc_pkg::DIST_WIDTH-1:0], clock_ms, $urandom_range(0, 14) == 0);
      if ($urandom_range(0, 4) == 0)
         glide(top, top);
      glide(top, low);
      glide(low, high);
      glide(high, back);
   endtask

   // A plain repetition at reset settings, with exact boundaries, then the distance extremes.
   task automatic test_basic_rep();
      stall_pct = 40;
      gap_max   = 3;
      burst_max = 3;
      send_sample(16'd5000, 32'd0, 1'b0);
      send_sample(16'd4000, 32'd10, 1'b0);
      send_sample(16'd3800, 32'd20, 1'b0);
      send_sample(16'd4100, 32'd30, 1'b0);
      send_sample(16'd4749, 32'd40, 1'b0);
      send_sample(16'd4750, 32'd50, 1'b0);
      send_sample(16'hFFFF, 32'd60, 1'b1);
      send_sample(16'd0, 32'd70, 1'b0);
      send_sample(16'hFFFF, 32'd80, 1'b0);
      send_sample(16'hFFFF, 32'd90, 1'b0);
   endtask

   // Movement threshold, idle limit at its edge and a timestamp that wraps.
   task automatic test_idle_timeout();
      logic [rc_pkg::TIME_WIDTH-1:0] base;
      base = 32'hFFFF_FF00;
      write_reg(rc_pkg::CSR_MAX_IDLE, 16'd500);
      send_sample(16'd2000, base, 1'b1);
      send_sample(16'd2020, base + 32'd100, 1'b0);
      send_sample(16'd1999, base + 32'd200, 1'b0);
      send_sample(16'd900, base + 32'd300, 1'b0);
      send_sample(16'd905, base + 32'd800, 1'b0);
      send_sample(16'd905, base + 32'd801, 1'b0);
   endtask

   // A goal below a quarter of the travel makes any descending sample a repetition.
   task automatic test_goal_below_zero();
      write_reg(rc_pkg::CSR_MIN_TRAVEL, 16'd100);
      send_sample(16'd150, 32'd1000, 1'b1);
      send_sample(16'd50, 32'd1010, 1'b0);
      write_reg(rc_pkg::CSR_MIN_TRAVEL, 16'd10000);
      send_sample(16'd3050, 32'd1020, 1'b0);
      send_sample(16'd0, 32'd1030, 1'b0);
   endtask

   // Ignored writes, spare indexes and the largest register values.
   task automatic test_register_writes();
      write_reg(rc_pkg::CSR_MIN_TRAVEL, 16'd0);
      write_reg(rc_pkg::CSR_MAX_IDLE, 16'd0);
      write_reg(rc_pkg::CSR_MIN_TRAVEL, 16'hC000);
      write_reg(CSR_SPARE_A, 16'h1234);
      write_reg(CSR_SPARE_B, 16'hFFFF);
      write_reg(rc_pkg::CSR_MIN_TRAVEL, 16'hFFFF);
      write_reg(rc_pkg::CSR_MAX_IDLE, 16'hFFFF);
      send_sample(16'd20000, 32'd5000, 1'b1);
      send_sample(16'd3617, 32'd5010, 1'b0);
      send_sample(16'd8531, 32'd5020, 1'b0);
      send_sample(16'd15905, 32'd5030, 1'b0);
   endtask

   // Mostly repetition shaped motion with random content, some noise and some pauses.
   task automatic test_random_motion();
      int start;
      for (int round = 0; round < 6; round++) begin
         case (round)
            0: begin
               write_reg(rc_pkg::CSR_MIN_TRAVEL, 16'd100);
               write_reg(rc_pkg::CSR_MAX_IDLE, 16'd500);
               stall_pct = 0;
               gap_max   = 0;
            end
            1: begin
               write_reg(rc_pkg::CSR_MIN_TRAVEL, 16'd10000);
               write_reg(rc_pkg::CSR_MAX_IDLE, 16'd60000);
               stall_pct = 50;
               gap_max   = 3;
            end
            2: begin
               write_reg(rc_pkg::CSR_MIN_TRAVEL, 16'h3FFF);
               write_reg(rc_pkg::CSR_MAX_IDLE, 16'hFFFF);
               stall_pct = 20;
               gap_max   = 6;
            end
            default: begin
               write_reg(rc_pkg::CSR_MIN_TRAVEL, 16'($urandom_range(100, 10000)));
               write_reg(rc_pkg::CSR_MAX_IDLE, 16'($urandom_range(500, 60000)));
               stall_pct = $urandom_range(0, 70);
               gap_max   = $urandom_range(0, 6);
            end
         endcase
         burst_max = $urandom_range(1, 12);
         clock_ms  = $urandom;
         start     = words_sent;
         while (words_sent - start < ROUND_WORDS) begin
            case ($urandom_range(0, 9))
               0: send_sample(16'($urandom_range(0, 65535)), $urandom,
                              $urandom_range(0, 9) == 0);
               1: drain_results();
               default: rep_motion();
            endcase
         end
      end
   endtask

   // Receiver stall pattern: runs of random length, stalled with the chance set by the test.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= ($urandom_range(0, 99) < stall_pct);
         stall_left <= $urandom_range(0, 5);
      end
   end

   // Compares each accepted result word with the oldest expectation.
   always @(posedge clock) begin : check_word
      rc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t ns: result word expected none, actual count %0d", $time,
                     rsp_reps_total);
         end else begin
            want = pending_results.pop_front();
            if (rsp_rep_done !== want.rep_done)
               note_mismatch("rep_done", want.rep_done, rsp_rep_done);
            if (rsp_reps_total !== want.reps_total)
               note_mismatch("reps_total", want.reps_total, rsp_reps_total);
            if (rsp_phase_now !== want.phase_now)
               note_mismatch("phase_now", want.phase_now, rsp_phase_now);
         end
      end
   end

   // Ends the run when neither channel has moved a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("repetition_counter test failed");
         $finish;
      end
   end

   initial begin
      travel_min = rc_pkg::MIN_TRAVEL_RESET;
      idle_limit = rc_pkg::MAX_IDLE_RESET;
      forget_tracking();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_basic_rep();
      test_idle_timeout();
      test_goal_below_zero();
      test_register_writes();
      test_random_motion();
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("repetition_counter test passed");
      else
         $display("repetition_counter test failed");
      $finish;
   end

endmodule

>>> repetition_counter.f
src/rc_pkg.sv
src/rc_csr.sv
src/rc_step.sv
src/repetition_counter.sv
bench/tb_repetition_counter.sv
